FILE: sv/cas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cas_pkg
// Shared widths, limits, register indexes and sequencer states of the
// cascaded averaging and stability filter.
// ----------------------------------------------------------------------------
package cas_pkg;

  // Field and accumulator widths
  localparam int unsigned RAW_W   = 24;
  localparam int unsigned VAL_W   = 20;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned WIN_LEN = 16;
  localparam int unsigned WIN_AW  = $clog2(WIN_LEN);
  localparam int unsigned SUM1_W  = RAW_W + WIN_AW;
  localparam int unsigned SUM2_W  = VAL_W + WIN_AW;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned STB_W   = 6;

  localparam int unsigned AVG_DEPTH_DEF = 8;

  // Limits
  localparam logic [RAW_W-1:0]  JUMP_LIMIT    = RAW_W'(50000);
  localparam logic [CNT_W-1:0]  SETTLE_LIMIT  = CNT_W'(15);
  localparam logic [CNT_W-1:0]  CNT_MAX       = '1;
  localparam logic [STB_W-1:0]  STB_MAX       = '1;
  localparam logic [STB_W-1:0]  THRESH_INNER  = STB_W'(30);
  localparam logic [STB_W-1:0]  THRESH_NORMAL = STB_W'(10);
  localparam logic [STEP_W-1:0] CODE_STEP_RST = STEP_W'(16);

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_CODE_STEP  = 3'd0,
    REG_INNER_CAL  = 3'd1,
    REG_LINEAR_CAL = 3'd2,
    REG_USER_CAL   = 3'd3
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_JUMP = 7'b0000010,
    ST_A    = 7'b0000100,
    ST_B    = 7'b0001000,
    ST_DST  = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_RES  = 7'b1000000
  } state_e;

  // Window control from the sequencer
  typedef struct packed {
    logic rd;
    logic upd;
  } win_ctrl_t;

endpackage
`default_nettype wire

FILE: sv/cas_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cas_window
// Sixteen-entry moving window with a running sum. A read fetches the oldest
// entry; an update replaces it with the new value and adjusts the sum.
// ----------------------------------------------------------------------------
module cas_window #(
  parameter int unsigned DW = cas_pkg::RAW_W,
  parameter int unsigned SW = cas_pkg::SUM1_W
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  cas_pkg::win_ctrl_t      ctrl_i,
  input  wire  [DW-1:0]           data_i,
  output logic [SW-1:0]           sum_o
);
  import cas_pkg::*;

  logic [DW-1:0]      mem_q [WIN_LEN];
  logic [DW-1:0]      old_q;
  logic               old_vld_q;
  logic [WIN_LEN-1:0] vld_q;
  logic [WIN_AW-1:0]  pos_q;
  logic [SW-1:0]      sum_q;
  logic [DW-1:0]      old_val;

  // Never-written entries count as zero
  assign old_val = old_vld_q ? old_q : '0;
  assign sum_o   = sum_q;

  // Window storage with registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      old_q <= mem_q[pos_q];
    end
    if (ctrl_i.upd) begin
      mem_q[pos_q] <= data_i;
    end
  end

  // Valid bits, position and running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_vld_q <= 1'b0;
      vld_q     <= '0;
      pos_q     <= '0;
      sum_q     <= '0;
    end else begin
      if (ctrl_i.rd) begin
        old_vld_q <= vld_q[pos_q];
      end
      if (ctrl_i.upd) begin
        vld_q[pos_q] <= 1'b1;
        pos_q        <= pos_q + 1'b1;
        sum_q        <= sum_q + SW'(data_i) - SW'(old_val);
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/cas_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cas_divider
// Restoring divider, one quotient bit per cycle. Done pulses for one cycle;
// the quotient holds until the next start.
// ----------------------------------------------------------------------------
module cas_divider #(
  parameter int unsigned DVD_W = 23,
  parameter int unsigned DVS_W = 4
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  wire  [DVD_W-1:0]    dividend_i,
  input  wire  [DVS_W-1:0]    divisor_i,
  output logic                done_o,
  output logic [DVD_W-1:0]    quot_o
);
  import cas_pkg::*;

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             fits;

  // Trial subtraction of one step
  assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign fits    = (rem_sh >= {1'b0, dvs_q});

  assign done_o = done_q;
  assign quot_o = dvd_q;

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], fits};
      rem_q <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CW'(DVD_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/cascaded_average_stability.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cascaded_average_stability
// Weighing-scale filter: two cascaded 16-sample windows, a bypass decision,
// a mean over a ring of AVG_DEPTH entries and stability detection.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   in      | input     | in_valid_i/in_stall_o | cmd_i, sample_i
//   out     | output    | out_valid_o/out_stall_i | filtered_o, stage_a_o,
//           |           |                       | stage_b_o, stable_o, flags
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A sample runs through jump check, stage A, stage B, divider start, the serial
// divider (one quotient bit per cycle, SUM3_W = 23 at depth 8) and result load;
// a break command goes straight to result load. No clearing pass: windows use
// valid bits, the ring uses its fill count. A new item is taken while a result
// waits; the sequencer holds before loading the result register until it is free.
// ----------------------------------------------------------------------------
module cascaded_average_stability #(
  parameter int unsigned AVG_DEPTH = cas_pkg::AVG_DEPTH_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire                          cmd_i,
  input  wire  [cas_pkg::RAW_W-1:0]    sample_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [cas_pkg::VAL_W-1:0]    filtered_o,
  output logic [cas_pkg::VAL_W-1:0]    stage_a_o,
  output logic [cas_pkg::VAL_W-1:0]    stage_b_o,
  output logic                         stable_o,
  output logic                         zero_track_enable_o,
  output logic                         load_track_enable_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [cas_pkg::IDX_W-1:0]    cfg_index_i,
  input  wire  [cas_pkg::CFG_W-1:0]    cfg_data_i
);
  import cas_pkg::*;

  localparam int unsigned RING_AW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int unsigned FILL_W  = $clog2(AVG_DEPTH + 1);
  localparam int unsigned SUM3_W  = VAL_W + $clog2(AVG_DEPTH);

  // Configuration
  logic [STEP_W-1:0] code_step_q;
  logic              inner_cal_q, linear_cal_q, user_cal_q;

  // Sequencer and item
  state_e            state_q, state_d;
  logic              cmd_q;
  logic [RAW_W-1:0]  sample_q;

  // Filter state
  logic [RAW_W-1:0]   last_raw_q;
  logic [VAL_W-1:0]   a_q, prev_b_q, final_q, ring_rd_q;
  logic [VAL_W-1:0]   ring_mem [AVG_DEPTH];
  logic [RING_AW-1:0] ring_pos_q;
  logic [FILL_W-1:0]  fill_q;
  logic [SUM3_W-1:0]  sum3_q;
  logic [CNT_W-1:0]   warm_q, settle_q;
  logic [STB_W-1:0]   stb_cnt_q;
  logic               stable_q;

  // Result register
  logic               out_valid_q;
  logic               out_free;
  logic               res_load;

  // Windows and divider
  win_ctrl_t          w1_ctrl, w2_ctrl;
  logic [SUM1_W-1:0]  sum1;
  logic [SUM2_W-1:0]  sum2;
  logic               div_start, div_done;
  logic [SUM3_W-1:0]  quot;

  // Combinational helpers
  logic               in_fire;
  logic [RAW_W-1:0]   raw_diff;
  logic               jump;
  logic [VAL_W-1:0]   stage_a, avg2, stage_b, mean;
  logic [VAL_W-1:0]   bp_diff, step10, mean_diff;
  logic               use_avg, close, ring_full;
  logic [CNT_W-1:0]   warm_inc, settle_inc;
  logic [STB_W-1:0]   stb_inc, thresh;

  assign in_fire     = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Raw jump detection
  assign raw_diff = (sample_q > last_raw_q) ? sample_q - last_raw_q : last_raw_q - sample_q;
  assign jump     = (raw_diff > JUMP_LIMIT);

  // Stage values
  assign stage_a = sum1[SUM1_W-1 -: VAL_W];
  assign avg2    = sum2[SUM2_W-1 -: VAL_W];
  assign step10  = (VAL_W'(code_step_q) << 3) + (VAL_W'(code_step_q) << 1);
  assign bp_diff = (final_q > prev_b_q) ? final_q - prev_b_q : prev_b_q - final_q;
  assign use_avg = (settle_q > SETTLE_LIMIT) || (bp_diff < step10);
  assign stage_b = use_avg ? avg2 : a_q;
  assign ring_full = (fill_q == FILL_W'(AVG_DEPTH));

  // Saturating counters
  assign warm_inc   = (warm_q == CNT_MAX) ? warm_q : warm_q + 1'b1;
  assign settle_inc = (settle_q == CNT_MAX) ? settle_q : settle_q + 1'b1;
  assign stb_inc    = (stb_cnt_q == STB_MAX) ? stb_cnt_q : stb_cnt_q + 1'b1;
  assign thresh     = inner_cal_q ? THRESH_INNER : THRESH_NORMAL;

  // Stability test on the new mean
  assign mean      = quot[VAL_W-1:0];
  assign mean_diff = (final_q > mean) ? final_q - mean : mean - final_q;
  assign close     = (mean_diff < VAL_W'(code_step_q));

  assign res_load  = (state_q == ST_RES) && out_free;

  // Window strobes
  assign w1_ctrl.rd  = in_fire;
  assign w1_ctrl.upd = (state_q == ST_JUMP);
  assign w2_ctrl.rd  = (state_q == ST_JUMP);
  assign w2_ctrl.upd = (state_q == ST_A);
  assign div_start   = (state_q == ST_DST);

  cas_window #(
    .DW (RAW_W),
    .SW (SUM1_W)
  ) u_win_one (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (w1_ctrl),
    .data_i (sample_q),
    .sum_o  (sum1)
  );

  cas_window #(
    .DW (VAL_W),
    .SW (SUM2_W)
  ) u_win_two (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (w2_ctrl),
    .data_i (stage_a),
    .sum_o  (sum2)
  );

  cas_divider #(
    .DVD_W (SUM3_W),
    .DVS_W (FILL_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum3_q),
    .divisor_i  (fill_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = cmd_i ? ST_RES : ST_JUMP;
      ST_JUMP: state_d = ST_A;
      ST_A:    state_d = ST_B;
      ST_B:    state_d = ST_DST;
      ST_DST:  state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_RES;
      ST_RES:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Ring storage with registered read
  always_ff @(posedge clk_i) begin
    if (state_q == ST_A) begin
      ring_rd_q <= ring_mem[ring_pos_q];
    end
    if (state_q == ST_B) begin
      ring_mem[ring_pos_q] <= stage_b;
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q    <= cmd_i;
      sample_q <= sample_i;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      if (cmd_q) begin
        filtered_o          <= final_q;
        stage_a_o           <= '0;
        stage_b_o           <= prev_b_q;
        stable_o            <= 1'b0;
        zero_track_enable_o <= 1'b0;
        load_track_enable_o <= 1'b0;
      end else begin
        filtered_o          <= mean;
        stage_a_o           <= a_q;
        stage_b_o           <= prev_b_q;
        stable_o            <= stable_q || (close && (stb_inc > thresh));
        zero_track_enable_o <= stable_q || (close && (stb_inc > thresh));
        load_track_enable_o <= (stable_q || (close && (stb_inc > thresh))) &&
                               linear_cal_q && !user_cal_q;
      end
    end
  end

  // Sequencer, configuration and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      code_step_q  <= CODE_STEP_RST;
      inner_cal_q  <= 1'b0;
      linear_cal_q <= 1'b0;
      user_cal_q   <= 1'b0;
      last_raw_q   <= '0;
      a_q          <= '0;
      prev_b_q     <= '0;
      final_q      <= '0;
      ring_pos_q   <= '0;
      fill_q       <= '0;
      sum3_q       <= '0;
      warm_q       <= '0;
      settle_q     <= '0;
      stb_cnt_q    <= '0;
      stable_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      // Register writes; unknown indexes drop
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_CODE_STEP:  code_step_q  <= cfg_data_i[STEP_W-1:0];
          REG_INNER_CAL:  inner_cal_q  <= cfg_data_i[0];
          REG_LINEAR_CAL: linear_cal_q <= cfg_data_i[0];
          REG_USER_CAL:   user_cal_q   <= cfg_data_i[0];
          default: ;
        endcase
      end

      // Jump check: restart warmup, ring fill and stability
      if (state_q == ST_JUMP) begin
        last_raw_q <= sample_q;
        if (jump) begin
          stable_q   <= 1'b0;
          stb_cnt_q  <= '0;
          warm_q     <= '0;
          settle_q   <= '0;
          fill_q     <= '0;
          ring_pos_q <= '0;
          sum3_q     <= '0;
        end
      end

      // First stage out, advance warmup and settle counters
      if (state_q == ST_A) begin
        a_q    <= stage_a;
        warm_q <= warm_inc;
        settle_q <= (warm_inc > SETTLE_LIMIT) ? settle_inc : '0;
      end

      // Select second stage, push into the ring
      if (state_q == ST_B) begin
        prev_b_q <= stage_b;
        sum3_q   <= sum3_q + SUM3_W'(stage_b) - (ring_full ? SUM3_W'(ring_rd_q) : '0);
        if (!ring_full) begin
          fill_q <= fill_q + 1'b1;
        end
        if (ring_pos_q == RING_AW'(AVG_DEPTH - 1)) begin
          ring_pos_q <= '0;
        end else begin
          ring_pos_q <= ring_pos_q + 1'b1;
        end
      end

      // Stability update and result hand-off
      if (res_load) begin
        if (cmd_q) begin
          stb_cnt_q <= '0;
          stable_q  <= 1'b0;
        end else begin
          final_q <= mean;
          if (close) begin
            stb_cnt_q <= stb_inc;
            if (stb_inc > thresh) begin
              stable_q <= 1'b1;
            end
          end else begin
            stb_cnt_q <= '0;
          end
        end
      end

      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: test/cas_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cas_checker
// Watches the sample, result and register channels of the weighing filter.
// Predicts each result from its own copy of the filter state and register
// values, and compares every result transfer field by field against the
// oldest predicted reading.
// ----------------------------------------------------------------------------
module cas_checker #(
  parameter int unsigned AVG_DEPTH = cas_pkg::AVG_DEPTH_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  input  wire                        in_stall_i,
  input  wire                        cmd_i,
  input  wire  [cas_pkg::RAW_W-1:0]  sample_i,
  input  wire                        out_valid_i,
  input  wire                        out_stall_i,
  input  wire  [cas_pkg::VAL_W-1:0]  filtered_i,
  input  wire  [cas_pkg::VAL_W-1:0]  stage_a_i,
  input  wire  [cas_pkg::VAL_W-1:0]  stage_b_i,
  input  wire                        stable_i,
  input  wire                        zero_track_i,
  input  wire                        load_track_i,
  input  wire                        cfg_valid_i,
  input  wire                        cfg_ready_i,
  input  wire  [cas_pkg::IDX_W-1:0]  cfg_index_i,
  input  wire  [cas_pkg::CFG_W-1:0]  cfg_data_i,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o
);
  import cas_pkg::*;

  localparam int unsigned BYPASS_STEPS = 10;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct packed {
    logic [VAL_W-1:0] filtered;
    logic [VAL_W-1:0] stage_a;
    logic [VAL_W-1:0] stage_b;
    logic             steady;
    logic             zero_trk;
    logic             load_trk;
  } weigh_res_t;

  // Register copies
  logic [STEP_W-1:0] step_q;
  logic              inner_q;
  logic              lin_q;
  logic              user_q;

  // Filter state copy
  logic [RAW_W-1:0]  prev_raw;
  logic [RAW_W-1:0]  win_a [WIN_LEN];
  logic [SUM1_W-1:0] acc_a;
  logic [WIN_AW-1:0] ptr_a;
  logic [VAL_W-1:0]  win_b [WIN_LEN];
  logic [SUM2_W-1:0] acc_b;
  logic [WIN_AW-1:0] ptr_b;
  logic [VAL_W-1:0]  ring [AVG_DEPTH];
  int unsigned       ring_ptr;
  int unsigned       ring_fill;
  logic [CNT_W-1:0]  warm_cnt;
  logic [CNT_W-1:0]  settle_cnt;
  logic [STB_W-1:0]  steady_cnt;
  logic              steady;
  logic [VAL_W-1:0]  out_val;
  logic [VAL_W-1:0]  last_b;

  weigh_res_t  pending_readings [$];
  int unsigned fail_cnt;
  int unsigned result_no;
  int unsigned waiting;

  assign fail_count_o = fail_cnt;
  assign pending_o    = waiting;

  function automatic logic [31:0] span(input logic [31:0] x, input logic [31:0] y);
    return (x > y) ? x - y : y - x;
  endfunction

  // Advance the filter copy by one input item and return the reading it gives
  function automatic weigh_res_t filter_sample(input logic c, input logic [RAW_W-1:0] s);
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] avg;
    logic [VAL_W-1:0] b;
    logic [VAL_W-1:0] mean;
    logic [STB_W-1:0] limit;
    int unsigned      total;
    int unsigned      i;
    weigh_res_t       r;
    if (c) begin
      // break: drop stability only, report held values
      steady_cnt = '0;
      steady     = 1'b0;
      r.filtered = out_val;
      r.stage_a  = '0;
      r.stage_b  = last_b;
      r.steady   = 1'b0;
      r.zero_trk = 1'b0;
      r.load_trk = 1'b0;
      return r;
    end
    // raw jump restarts settling and the ring fill
    if (span(32'(s), 32'(prev_raw)) > JUMP_LIMIT) begin
      steady     = 1'b0;
      steady_cnt = '0;
      warm_cnt   = '0;
      settle_cnt = '0;
      ring_fill  = 0;
      ring_ptr   = 0;
    end
    prev_raw = s;

    // first window
    acc_a        = acc_a + s - win_a[ptr_a];
    win_a[ptr_a] = s;
    ptr_a        = ptr_a + 1'b1;
    a            = acc_a[SUM1_W-1:8];

    if (warm_cnt != CNT_MAX) warm_cnt = warm_cnt + 1'b1;
    if (warm_cnt > SETTLE_LIMIT) begin
      if (settle_cnt != CNT_MAX) settle_cnt = settle_cnt + 1'b1;
    end else begin
      settle_cnt = '0;
    end

    // second window and bypass choice
    acc_b        = acc_b + a - win_b[ptr_b];
    win_b[ptr_b] = a;
    ptr_b        = ptr_b + 1'b1;
    avg          = acc_b[SUM2_W-1:WIN_AW];
    if (settle_cnt > SETTLE_LIMIT ||
        span(32'(out_val), 32'(last_b)) < BYPASS_STEPS * step_q) begin
      b = avg;
    end else begin
      b = a;
    end
    last_b = b;

    // ring mean over filled entries
    ring[ring_ptr] = b;
    ring_ptr = ring_ptr + 1;
    if (ring_ptr >= AVG_DEPTH) ring_ptr = 0;
    if (ring_fill < AVG_DEPTH) ring_fill = ring_fill + 1;
    total = 0;
    for (i = 0; i < ring_fill; i++) total = total + ring[i];
    mean = VAL_W'(total / ring_fill);

    // stability count
    if (span(32'(out_val), 32'(mean)) < step_q) begin
      if (steady_cnt != STB_MAX) steady_cnt = steady_cnt + 1'b1;
      limit = inner_q ? THRESH_INNER : THRESH_NORMAL;
      if (steady_cnt > limit) steady = 1'b1;
    end else begin
      steady_cnt = '0;
    end
    out_val = mean;

    r.filtered = out_val;
    r.stage_a  = a;
    r.stage_b  = b;
    r.steady   = steady;
    r.zero_trk = steady;
    r.load_trk = steady && lin_q && !user_q;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (want !== got) begin
      if (fail_cnt < REPORT_MAX) begin
        $display("mismatch in %s of result %0d: expected %0h, got %0h",
                 what, result_no, want, got);
      end
      fail_cnt++;
    end
  endtask

  // Track every transfer on the three channels
  always @(posedge clk_i or negedge rst_ni) begin : watch
    weigh_res_t want;
    int unsigned k;
    if (!rst_ni) begin
      step_q     = CODE_STEP_RST;
      inner_q    = 1'b0;
      lin_q      = 1'b0;
      user_q     = 1'b0;
      prev_raw   = '0;
      acc_a      = '0;
      ptr_a      = '0;
      acc_b      = '0;
      ptr_b      = '0;
      ring_ptr   = 0;
      ring_fill  = 0;
      warm_cnt   = '0;
      settle_cnt = '0;
      steady_cnt = '0;
      steady     = 1'b0;
      out_val    = '0;
      last_b     = '0;
      for (k = 0; k < WIN_LEN; k++) begin
        win_a[k] = '0;
        win_b[k] = '0;
      end
      for (k = 0; k < AVG_DEPTH; k++) ring[k] = '0;
      pending_readings.delete();
      fail_cnt  = 0;
      result_no = 0;
      waiting   = 0;
    end else begin
      // compare a result transfer with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (pending_readings.size() == 0) begin
          if (fail_cnt < REPORT_MAX) begin
            $display("result %0d arrived with no reading predicted", result_no);
          end
          fail_cnt++;
        end else begin
          want = pending_readings.pop_front();
          check_field("filtered", want.filtered, filtered_i);
          check_field("stage_a", want.stage_a, stage_a_i);
          check_field("stage_b", want.stage_b, stage_b_i);
          check_field("stable", VAL_W'(want.steady), VAL_W'(stable_i));
          check_field("zero_track_enable", VAL_W'(want.zero_trk), VAL_W'(zero_track_i));
          check_field("load_track_enable", VAL_W'(want.load_trk), VAL_W'(load_track_i));
        end
        result_no++;
      end
      // predict the reading of an accepted input transfer
      if (in_valid_i && !in_stall_i) begin
        pending_readings.push_back(filter_sample(cmd_i, sample_i));
      end
      // mirror register writes; unused indexes are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_CODE_STEP:  step_q  = cfg_data_i[STEP_W-1:0];
          REG_INNER_CAL:  inner_q = cfg_data_i[0];
          REG_LINEAR_CAL: lin_q   = cfg_data_i[0];
          REG_USER_CAL:   user_q  = cfg_data_i[0];
          default: ;
        endcase
      end
      waiting = pending_readings.size();
    end
  end

endmodule
`default_nettype wire

FILE: test/tb_cascaded_average_stability.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_cascaded_average_stability
// Drives the weighing filter with a directed set of edge samples and then
// with random steady runs, drifts, jumps, noise and break commands under a
// series of register settings, with random idle cycles on both channels.
// The checker beside the block predicts and compares every reading.
// ----------------------------------------------------------------------------
module tb_cascaded_average_stability;
  import cas_pkg::*;

  localparam int unsigned DEPTH         = AVG_DEPTH_DEF;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS   = 110;
  localparam int          RAW_MAX       = (1 << RAW_W) - 1;
  localparam int          TIMEOUT       = 12 * 300000;
  localparam logic [IDX_W-1:0] REG_FIRST_UNUSED = IDX_W'(4);

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              cmd;
  logic [RAW_W-1:0]  sample;
  logic              out_valid;
  logic              out_stall;
  logic [VAL_W-1:0]  filtered;
  logic [VAL_W-1:0]  stage_a;
  logic [VAL_W-1:0]  stage_b;
  logic              stable;
  logic              zero_trk;
  logic              load_trk;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  int unsigned       fail_total;
  int unsigned       exp_waiting;
  logic              quiet;
  int                last_base;

  cascaded_average_stability #(
    .AVG_DEPTH (DEPTH)
  ) u_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .cmd_i               (cmd),
    .sample_i            (sample),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .filtered_o          (filtered),
    .stage_a_o           (stage_a),
    .stage_b_o           (stage_b),
    .stable_o            (stable),
    .zero_track_enable_o (zero_trk),
    .load_track_enable_o (load_trk),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  cas_checker #(
    .AVG_DEPTH (DEPTH)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .cmd_i        (cmd),
    .sample_i     (sample),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .filtered_i   (filtered),
    .stage_a_i    (stage_a),
    .stage_b_i    (stage_b),
    .stable_i     (stable),
    .zero_track_i (zero_trk),
    .load_track_i (load_trk),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_total),
    .pending_o    (exp_waiting)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop
  initial begin
    #(TIMEOUT);
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned idle_draw();
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic int clip_raw(input int v);
    if (v < 0) return 0;
    if (v > RAW_MAX) return RAW_MAX;
    return v;
  endfunction

  // Result side: stall a random number of cycles before each transfer
  initial begin : result_sink
    int unsigned n;
    out_stall = 1'b1;
    wait (rst_n);
    forever begin
      n = idle_draw();
      @(negedge clk);
      out_stall = (n != 0);
      if (n != 0) begin
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Present one item after a random gap and hold it until its transfer
  task automatic send_item(input logic c, input logic [RAW_W-1:0] s);
    int unsigned gap;
    gap = idle_draw();
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    cmd      = c;
    sample   = s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all registers; one-bit ones carry random upper bits
  task automatic load_setup(input logic [STEP_W-1:0] step, input logic inner,
                            input logic lin, input logic user);
    write_reg(REG_FIRST_UNUSED + IDX_W'($urandom_range(0, 3)), CFG_W'($urandom));
    write_reg(REG_CODE_STEP, CFG_W'(step));
    write_reg(REG_INNER_CAL, (CFG_W'($urandom) << 1) | CFG_W'(inner));
    write_reg(REG_LINEAR_CAL, (CFG_W'($urandom) << 1) | CFG_W'(lin));
    write_reg(REG_USER_CAL, (CFG_W'($urandom) << 1) | CFG_W'(user));
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stop sending and wait until every predicted reading has arrived
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (exp_waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Random mix of steady runs, drifts, noise and break commands
  task automatic run_random(input int unsigned target);
    int unsigned made;
    int unsigned len;
    int unsigned k;
    int          amp;
    int          drift;
    int          base;
    int          off;
    made = 0;
    while (made < target) begin
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: begin
          // noise burst
          len = $urandom_range(1, 6);
          for (k = 0; k < len; k++) send_item($urandom_range(0, 7) == 0, RAW_W'($urandom));
        end
        9: begin
          // break commands
          len = $urandom_range(1, 3);
          for (k = 0; k < len; k++) send_item(1'b1, RAW_W'($urandom));
        end
        default: begin
          // steady run around a base, maybe drifting
          case ($urandom_range(0, 3))
            0:       base = int'($urandom_range(0, 2000));
            1:       base = RAW_MAX - int'($urandom_range(0, 2000));
            2:       base = clip_raw(last_base + int'($urandom_range(0, 80000)) - 40000);
            default: base = int'($urandom_range(0, RAW_MAX));
          endcase
          case ($urandom_range(0, 9))
            0, 1, 2: amp = 0;
            3, 4, 5: amp = 15;
            6, 7:    amp = 255;
            8:       amp = 4095;
            default: amp = 60000;
          endcase
          drift = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 64)) - 32 : 0;
          len   = $urandom_range(20, 70);
          for (k = 0; k < len; k++) begin
            off = int'($urandom_range(0, 2 * amp)) - amp;
            send_item($urandom_range(0, 49) == 0,
                      RAW_W'(clip_raw(base + drift * int'(k) + off)));
          end
          last_base = base;
        end
      endcase
      made = made + len;
    end
    quiet = 1'b0;
  endtask

  // Stimulus and verdict
  initial begin
    in_valid  = 1'b0;
    cmd       = 1'b0;
    sample    = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    quiet     = 1'b0;
    last_base = 0;
    rst_n     = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed: jump limit edges, full scale, break commands
    send_item(1'b0, '0);
    send_item(1'b0, RAW_W'(50000));
    send_item(1'b0, RAW_W'(100001));
    send_item(1'b1, '1);
    send_item(1'b0, '1);
    repeat (18) send_item(1'b0, '1);
    send_item(1'b1, '0);
    send_item(1'b0, '0);
    drain();

    // register settings, extremes included
    load_setup(STEP_W'(16), 1'b0, 1'b1, 1'b0);
    run_random(PHASE_ITEMS);
    drain();
    load_setup(STEP_W'(1), 1'b1, 1'b1, 1'b1);
    run_random(PHASE_ITEMS);
    drain();
    load_setup('1, 1'b0, 1'b0, 1'b0);
    run_random(PHASE_ITEMS);
    drain();
    load_setup('0, 1'b1, 1'b1, 1'b0);
    run_random(PHASE_ITEMS);
    drain();
    load_setup(STEP_W'(4), 1'b0, 1'b1, 1'b0);
    run_random(PHASE_ITEMS);
    drain();
    load_setup(STEP_W'(200), 1'b1, 1'b0, 1'b1);
    run_random(PHASE_ITEMS);
    drain();

    if (fail_total == 0 && exp_waiting == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
sv/cas_pkg.sv
sv/cas_window.sv
sv/cas_divider.sv
sv/cascaded_average_stability.sv
test/cas_checker.sv
test/tb_cascaded_average_stability.sv
